// ===== rtl/core/awf_pkg.sv =====
// Package for the anagram word filter: shared constants, register codes and
// the control struct that the slot cells receive. No dependencies.
`default_nettype none

package awf_pkg;

    localparam int NUM_SLOTS    = 16;
    localparam int MAX_WORD_LEN = 16;
    localparam int DICT_WORDS   = 65536;

    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 5;
    localparam int COUNT_W = 10;
    localparam int INDEX_W = 16;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 5;

    localparam logic [LEN_W-1:0]   MAX_LEN_VAL       = LEN_W'(MAX_WORD_LEN);
    localparam logic [INDEX_W-1:0] LAST_WORD         = INDEX_W'(DICT_WORDS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
    localparam logic [COUNT_W-1:0] MAX_MATCHES_RESET = COUNT_W'(100);
    localparam logic [LEN_W-1:0]   TARGET_LEN_RESET  = LEN_W'(1);

    typedef enum logic [1:0] {
        REG_TARGET_LOW  = 2'd0,
        REG_TARGET_HIGH = 2'd1,
        REG_TARGET_LEN  = 2'd2,
        REG_MAX_MATCHES = 2'd3
    } cfg_reg_t;

    // step: an input byte is being processed this cycle.
    // clear: release every slot (word end or scan restart).
    typedef struct packed {
        logic step;
        logic clear;
    } slot_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/awf_slot_cell.sv =====
// One target slot of the anagram word filter: holds its used flag and passes
// the claim search on to the next slot. Depends on awf_pkg.
`default_nettype none

module awf_slot_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  awf_pkg::slot_ctrl_t            ctrl,
    input  logic [awf_pkg::CHAR_W-1:0]     target_byte,
    input  logic                           slot_en,
    input  logic [awf_pkg::CHAR_W-1:0]     char_code,
    input  logic                           search_in,
    output logic                           search_out
);
    import awf_pkg::*;

    logic used_reg;
    logic used_next;
    logic hit;

    // The first free slot holding an equal byte takes the byte and stops the search.
    assign hit        = search_in && slot_en && !used_reg && (target_byte == char_code);
    assign search_out = search_in && !hit;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            used_next = 1'b0;
        end
        else if (ctrl.step && hit)
        begin
            used_next = 1'b1;
        end
        else
        begin
            used_next = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/awf_slot_chain.sv =====
// Row of slot cells for the anagram word filter; the claim search ripples
// from slot 0 upward. Depends on awf_pkg and awf_slot_cell.
`default_nettype none

module awf_slot_chain (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  awf_pkg::slot_ctrl_t                       ctrl,
    input  logic [awf_pkg::NUM_SLOTS*awf_pkg::CHAR_W-1:0] target_bytes,
    input  logic [awf_pkg::LEN_W-1:0]                 target_length,
    input  logic [awf_pkg::CHAR_W-1:0]                char_code,
    input  logic                                      search_en,
    output logic                                      claimed
);
    import awf_pkg::*;

    logic [NUM_SLOTS:0] search;

    assign search[0] = search_en;

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        awf_slot_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .target_byte(target_bytes[i*CHAR_W +: CHAR_W]),
            .slot_en    (target_length > LEN_W'(i)),
            .char_code  (char_code),
            .search_in  (search[i]),
            .search_out (search[i+1])
        );
    end

    // The search was stopped somewhere along the row exactly when a slot took the byte.
    assign claimed = search_en && !search[NUM_SLOTS];

endmodule

`default_nettype wire

// ===== rtl/core/anagram_word_filter.sv =====
// Anagram word filter: one dictionary byte per cycle in, one result per word out. Each
// word's result is registered onto m_tdata in the cycle after its last byte is accepted.
// The byte rate rests on the combinational claim ripple through the sixteen slot cells;
// the output register lets the next byte in while a result is taken; a stalled result
// blocks it. Reset (rst_n low, asynchronous) clears the scan, the output valid and the
// configuration registers to their defaults. Depends on awf_pkg and awf_slot_chain.
`default_nettype none

module anagram_word_filter #(
    parameter int MAX_WORD_LEN = awf_pkg::MAX_WORD_LEN,
    parameter int DICT_WORDS   = awf_pkg::DICT_WORDS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input byte stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_code
    input  logic                           s_tlast,   // word_end
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [0] is_anagram, [16:1] word_index,
                                                      // [26:17] match_count,
                                                      // [27] limit_reached, [31:28] zero
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [awf_pkg::ADDR_W-1:0]     paddr,
    input  logic [awf_pkg::CFG_W-1:0]      pwdata,
    output logic [awf_pkg::CFG_W-1:0]      prdata,
    output logic                           pready
);
    import awf_pkg::*;

    // Longest word that can still match, and index of the last dictionary word.
    localparam logic [LEN_W-1:0]   MAX_LEN_LIMIT = LEN_W'(MAX_WORD_LEN);
    localparam logic [INDEX_W-1:0] LAST_INDEX    = INDEX_W'(DICT_WORDS - 1);

    // Configuration registers.
    logic [CFG_W-1:0]   target_low_reg;
    logic [CFG_W-1:0]   target_high_reg;
    logic [LEN_W-1:0]   target_len_reg;
    logic [COUNT_W-1:0] max_matches_reg;

    // Scan state.
    logic [LEN_W-1:0]   bytes_seen_reg,  bytes_seen_next;
    logic               word_failed_reg, word_failed_next;
    logic [COUNT_W-1:0] found_count_reg, found_count_next;
    logic [INDEX_W-1:0] word_counter_reg, word_counter_next;
    logic               scan_done_reg,   scan_done_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_data_reg,  out_data_next;

    logic               cfg_write;
    cfg_reg_t           cfg_sel;
    logic               in_accept;
    logic               step;
    logic               word_done;
    logic               overlong;
    logic               claimed;
    slot_ctrl_t         slot_ctrl;

    // Per-word working values.
    logic [LEN_W-1:0]   bytes_val;
    logic               failed_val;
    logic               match;
    logic [COUNT_W-1:0] found_val;
    logic               limit_hit;

    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    // A new byte is taken whenever the output register is empty or is being drained.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    // Once the scan has finished, bytes are still taken but dropped.
    assign step      = in_accept && !scan_done_reg;
    assign word_done = step && s_tlast;
    assign overlong  = bytes_seen_reg >= MAX_LEN_LIMIT;

    assign slot_ctrl.step  = step;
    assign slot_ctrl.clear = cfg_write || word_done;

    awf_slot_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (slot_ctrl),
        .target_bytes ({target_high_reg, target_low_reg}),
        .target_length(target_len_reg),
        .char_code    (s_tdata[CHAR_W-1:0]),
        .search_en    (!overlong),
        .claimed      (claimed)
    );

    // The byte counter stops at the maximum word length and the word fails from
    // then on; otherwise the word fails when no free slot holds the byte.
    always_comb
    begin
        bytes_val  = overlong ? bytes_seen_reg : bytes_seen_reg + LEN_W'(1);
        failed_val = word_failed_reg || overlong || !claimed;
        match      = !failed_val && (bytes_val == target_len_reg);
        found_val  = (match && (found_count_reg != COUNT_MAX))
                     ? found_count_reg + COUNT_W'(1) : found_count_reg;
        limit_hit  = match && (found_val == max_matches_reg);
    end

    always_comb
    begin
        bytes_seen_next   = bytes_seen_reg;
        word_failed_next  = word_failed_reg;
        found_count_next  = found_count_reg;
        word_counter_next = word_counter_reg;
        scan_done_next    = scan_done_reg;
        priority if (cfg_write)
        begin
            bytes_seen_next   = '0;
            word_failed_next  = 1'b0;
            found_count_next  = '0;
            word_counter_next = '0;
            scan_done_next    = 1'b0;
        end
        else if (word_done)
        begin
            bytes_seen_next  = '0;
            word_failed_next = 1'b0;
            found_count_next = found_val;
            // The last dictionary word ends the scan and keeps its index.
            if (word_counter_reg >= LAST_INDEX)
            begin
                scan_done_next = 1'b1;
            end
            else
            begin
                word_counter_next = word_counter_reg + INDEX_W'(1);
                scan_done_next    = limit_hit;
            end
        end
        else if (step)
        begin
            bytes_seen_next  = bytes_val;
            word_failed_next = failed_val;
        end
        else
        begin
            bytes_seen_next = bytes_seen_reg;
        end
    end

    always_comb
    begin
        out_data_next = {4'b0000, limit_hit, found_val, word_counter_reg, match};
        if (word_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg   <= '0;
            word_failed_reg  <= 1'b0;
            found_count_reg  <= '0;
            word_counter_reg <= '0;
            scan_done_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            bytes_seen_reg   <= bytes_seen_next;
            word_failed_reg  <= word_failed_next;
            found_count_reg  <= found_count_next;
            word_counter_reg <= word_counter_next;
            scan_done_reg    <= scan_done_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // The result payload only loads at a word end and needs no reset.
    always_ff @(posedge clk)
    begin
        if (word_done)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Configuration registers. Any write restarts the scan through cfg_write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_low_reg  <= '0;
            target_high_reg <= '0;
            target_len_reg  <= TARGET_LEN_RESET;
            max_matches_reg <= MAX_MATCHES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_TARGET_LOW:  target_low_reg  <= pwdata;
                REG_TARGET_HIGH: target_high_reg <= pwdata;
                REG_TARGET_LEN:  target_len_reg  <= pwdata[LEN_W-1:0];
                REG_MAX_MATCHES: max_matches_reg <= pwdata[COUNT_W-1:0];
                default:         target_low_reg  <= target_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_TARGET_LOW:  prdata = target_low_reg;
            REG_TARGET_HIGH: prdata = target_high_reg;
            REG_TARGET_LEN:  prdata = CFG_W'(target_len_reg);
            REG_MAX_MATCHES: prdata = CFG_W'(max_matches_reg);
            default:         prdata = '0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/awf_checker.sv =====
// Port-level checks for the anagram word filter, bound to the top level.
// Depends on anagram_word_filter and awf_pkg.
`default_nettype none

module awf_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic                       s_tlast,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [31:0]                m_tdata
);
    import awf_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid after a reset cycle");

    // A fresh result follows a transaction that carried a word's last byte.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a preceding word end");

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A full, stalled output register blocks the input side.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result is stalled");

    // With the output register empty the input side is always open.
    a_open_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind anagram_word_filter awf_checker u_awf_checker (.*);

`default_nettype wire

// ===== tb/sv/anagram_word_filter_tb.sv =====
// Self-checking testbench for anagram_word_filter: streams dictionary words in,
// predicts each per-word verdict in SystemVerilog and compares the result stream.
// Depends on awf_pkg and the anagram_word_filter RTL only.
`timescale 1ns / 100ps

module anagram_word_filter_tb;

    import awf_pkg::*;

    // Clock period is 8 ns. The cycle limit is far above the slowest legal
    // run: about 1550 random bytes, each with the longest input gap and the
    // longest result stall, plus the register writes between phases.
    localparam int          HALF_PERIOD  = 4;
    localparam int          RESET_CYCLES = 10;
    localparam int          RANDOM_BYTES = 1550;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          ERROR_PRINTS = 100;

    typedef logic [7:0] char_t;

    // One byte transaction on the input stream.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } feed_item_t;

    // One result transaction, laid out exactly as m_tdata (bit 0 at the bottom).
    typedef struct packed {
        logic [3:0]         pad;
        logic               limit_reached;
        logic [COUNT_W-1:0] match_count;
        logic [INDEX_W-1:0] word_index;
        logic               is_anagram;
    } word_verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;     // [7:0] char_code
    logic               s_tlast = 1'b0;   // word_end

    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;          // [0] is_anagram, [16:1] word_index,
                                          // [26:17] match_count, [27] limit_reached

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [CFG_W-1:0]   pwdata = '0;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    anagram_word_filter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the filter. The configuration mirrors the registers
    // and the scan state follows every accepted byte, so the expected
    // verdict of each word is known the moment its last byte is taken.
    // ------------------------------------------------------------------
    logic [127:0]       key_word = '0;        // target bytes, slot 0 in bits 7:0
    logic [LEN_W-1:0]   key_len = TARGET_LEN_RESET;
    logic [COUNT_W-1:0] hit_limit = MAX_MATCHES_RESET;

    logic [NUM_SLOTS-1:0] slot_taken = '0;
    logic [LEN_W-1:0]     word_len = '0;
    bit                   word_bad = 1'b0;
    logic [COUNT_W-1:0]   hit_count = '0;
    logic [INDEX_W-1:0]   word_pos = '0;
    bit                   scan_halted = 1'b0;

    word_verdict_t      pending_verdicts[$];
    feed_item_t         byte_feed[$];
    int unsigned        bytes_taken = 0;      // bytes accepted by the block
    int unsigned        error_count = 0;
    int unsigned        cycle_count = 0;

    // Any register write throws away the whole scan, a half-received word too.
    task automatic clear_scan();
        slot_taken  = '0;
        word_len    = '0;
        word_bad    = 1'b0;
        hit_count   = '0;
        word_pos    = '0;
        scan_halted = 1'b0;
    endtask

    // Advance the shadow scan by one accepted byte and queue the verdict
    // when the byte closes a word.
    task automatic screen_byte(input feed_item_t item);
        int unsigned   live;
        bit            claimed;
        bit            hit;
        word_verdict_t verdict;
        bytes_taken++;
        if (scan_halted)
            return;
        // A word that has already filled every position fails on its next byte,
        // and its length stays pinned at the maximum.
        if (word_len >= MAX_WORD_LEN)
            word_bad = 1'b1;
        else
        begin
            word_len++;
            // Lengths above the slot count only have sixteen real slots behind them.
            live = (key_len < NUM_SLOTS) ? key_len : NUM_SLOTS;
            claimed = 1'b0;
            // The byte claims the lowest free slot that holds the same value.
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (!claimed && s < live && !slot_taken[s] && key_word[8*s +: 8] == item.code)
                begin
                    slot_taken[s] = 1'b1;
                    claimed = 1'b1;
                end
            end
            if (!claimed)
                word_bad = 1'b1;
        end
        if (!item.last)
            return;

        hit = !word_bad && word_len == key_len;
        verdict = '0;
        verdict.is_anagram = hit;
        if (hit)
        begin
            if (hit_count != COUNT_MAX)
                hit_count++;
            // A limit of zero never compares equal, so only the dictionary end stops it.
            if (hit_count == hit_limit)
            begin
                verdict.limit_reached = 1'b1;
                scan_halted = 1'b1;
            end
        end
        verdict.word_index = word_pos;
        if (word_pos == LAST_WORD)
            scan_halted = 1'b1;
        else
            word_pos++;
        verdict.match_count = hit_count;
        pending_verdicts.push_back(verdict);
        slot_taken = '0;
        word_len   = '0;
        word_bad   = 1'b0;
    endtask

    function automatic int unsigned pause_draw(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    task automatic flag_field(input string field, input int unsigned want,
                              input int unsigned got);
        error_count++;
        if (error_count <= ERROR_PRINTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // Compare one result transaction with the oldest prediction.
    task automatic check_verdict(input word_verdict_t got);
        word_verdict_t want;
        if (pending_verdicts.size() == 0)
        begin
            error_count++;
            if (error_count <= ERROR_PRINTS)
                $display("%0t ns: result with nothing expected, expected none, got %h",
                         $time, got);
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.is_anagram !== want.is_anagram)
            flag_field("is_anagram", want.is_anagram, got.is_anagram);
        if (got.word_index !== want.word_index)
            flag_field("word_index", want.word_index, got.word_index);
        if (got.match_count !== want.match_count)
            flag_field("match_count", want.match_count, got.match_count);
        if (got.limit_reached !== want.limit_reached)
            flag_field("limit_reached", want.limit_reached, got.limit_reached);
        if (got.pad !== want.pad)
            flag_field("reserved bits", want.pad, got.pad);
    endtask

    // ------------------------------------------------------------------
    // Input driver. A byte is handed to the shadow scan at the edge where
    // its transaction completes; the next byte follows after a random gap.
    // ------------------------------------------------------------------
    int unsigned feed_pause = 0;
    bit          feed_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            feed_pause = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                screen_byte('{code: s_tdata, last: s_tlast});
            if (!s_tvalid || s_tready)
            begin
                if (feed_pause != 0)
                begin
                    feed_pause--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_feed.size() != 0)
                begin
                    s_tdata  <= byte_feed[0].code;
                    s_tlast  <= byte_feed[0].last;
                    s_tvalid <= 1'b1;
                    void'(byte_feed.pop_front());
                    // Now and then switch between gapped traffic and a gap-free stretch.
                    if ($urandom_range(0, 29) == 0)
                        feed_calm = !feed_calm;
                    feed_pause = pause_draw(feed_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Every result transaction is checked, then tready may be
    // held low for a randomly drawn stall.
    // ------------------------------------------------------------------
    int unsigned drain_stall = 0;
    bit          drain_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            drain_stall = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            check_verdict(word_verdict_t'(m_tdata));
            if ($urandom_range(0, 29) == 0)
                drain_calm = !drain_calm;
            drain_stall = pause_draw(drain_calm);
            m_tready <= (drain_stall == 0);
        end
        else if (drain_stall != 0)
        begin
            drain_stall--;
            m_tready <= (drain_stall == 0);
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_byte(input char_t code, input bit last);
        byte_feed.push_back('{code: code, last: last});
    endtask

    task automatic push_text(input string text, input bit closed);
        for (int i = 0; i < text.len(); i++)
            push_byte(text[i], closed && i == text.len() - 1);
    endtask

    task automatic push_chars(input char_t chars[$], input bit closed);
        for (int i = 0; i < chars.size(); i++)
            push_byte(chars[i], closed && i == chars.size() - 1);
    endtask

    // Block until every queued byte is taken and every verdict has arrived.
    // A trailing open word produces nothing, so spare cycles follow to cover the
    // registered result before the configuration moves.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_feed.size() != 0 || s_tvalid || pending_verdicts.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Two-phase register write; it lands at the edge that ends the access phase.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TARGET_LOW:  key_word[63:0]   = value;
            REG_TARGET_HIGH: key_word[127:64] = value;
            REG_TARGET_LEN:  key_len          = value[LEN_W-1:0];
            REG_MAX_MATCHES: hit_limit        = value[COUNT_W-1:0];
            default: ;
        endcase
        clear_scan();
    endtask

    // Cycle limit: reaching it means the block hung or stopped answering.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        char_t              key_set[$];
        char_t              word[$];
        logic [127:0]       pattern;
        logic [LEN_W-1:0]   len_pick;
        logic [COUNT_W-1:0] limit_pick;
        int unsigned        live;
        int unsigned        word_total;
        int unsigned        kind;
        int unsigned        j;
        bit                 narrow;
        char_t              swap;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: a one-byte target of value zero, limit one hundred.
        @(negedge clk);
        push_byte(8'h00, 1'b1);     // a zero byte is an ordinary character and matches
        push_byte(8'hFF, 1'b1);     // top byte value, no match
        push_byte(8'h41, 1'b0);     // open word, discarded by the write below
        wait_idle();

        // Target "tea" with a match limit of two; the upper slots are all ones
        // but sit beyond the target length.
        write_reg(REG_TARGET_LOW, 64'h0000_0000_0061_6574);
        write_reg(REG_TARGET_HIGH, '1);
        write_reg(REG_TARGET_LEN, CFG_W'(3));
        write_reg(REG_MAX_MATCHES, CFG_W'(2));
        @(negedge clk);
        push_text("eat", 1'b1);     // permutation, first match
        push_text("tee", 1'b1);     // second 'e' finds no free slot
        push_text("ea", 1'b1);      // right bytes, too short
        push_text("ate", 1'b1);     // second match hits the limit
        push_text("tea", 1'b1);     // scan has stopped, ignored
        wait_idle();

        // Random phases: a fresh configuration each time, then mostly
        // permutations of the target mixed with near misses and noise.
        while (bytes_taken < RANDOM_BYTES)
        begin
            narrow = ($urandom_range(0, 1) == 0);
            case ($urandom_range(0, 7))
                0:       pattern = '0;
                1:       pattern = '1;
                default:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        pattern[8*i +: 8] = narrow ? char_t'(8'h61 + $urandom_range(0, 3))
                                                   : char_t'($urandom_range(0, 255));
                end
            endcase
            case ($urandom_range(0, 11))
                0:       len_pick = LEN_W'(1);
                1, 2:    len_pick = LEN_W'(16);
                3:       len_pick = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'd31;
                default: len_pick = LEN_W'($urandom_range(2, 15));
            endcase
            case ($urandom_range(0, 9))
                0:       limit_pick = COUNT_W'(1);
                1:       limit_pick = COUNT_W'(1023);
                2:       limit_pick = COUNT_W'(0);
                3:       limit_pick = COUNT_W'($urandom_range(2, 6));
                default: limit_pick = COUNT_W'($urandom_range(7, 1023));
            endcase
            write_reg(REG_TARGET_LOW, pattern[63:0]);
            write_reg(REG_TARGET_HIGH, pattern[127:64]);
            write_reg(REG_TARGET_LEN, CFG_W'(len_pick));
            write_reg(REG_MAX_MATCHES, CFG_W'(limit_pick));

            live = (len_pick < NUM_SLOTS) ? len_pick : NUM_SLOTS;
            key_set = {};
            for (int i = 0; i < live; i++)
                key_set.push_back(pattern[8*i +: 8]);

            @(negedge clk);
            word_total = $urandom_range(20, 60);
            for (int w = 0; w < word_total; w++)
            begin
                // Start from a shuffled copy of the target.
                word = key_set;
                for (int i = word.size() - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    swap = word[i];
                    word[i] = word[j];
                    word[j] = swap;
                end
                kind = $urandom_range(0, 19);
                if (kind >= 15 || word.size() == 0)
                begin
                    // Over-long words or free-form words of any allowed length.
                    word = {};
                    repeat ((kind == 15) ? $urandom_range(17, 20) : $urandom_range(1, 16))
                    begin
                        if (key_set.size() != 0 && $urandom_range(0, 2) != 0)
                            word.push_back(key_set[$urandom_range(0, key_set.size() - 1)]);
                        else
                            word.push_back(char_t'($urandom_range(1, 255)));
                    end
                end
                else if (kind == 11 || kind == 12)
                    word[$urandom_range(0, word.size() - 1)] = char_t'($urandom_range(1, 255));
                else if (kind == 13 && word.size() > 1)
                    word.delete($urandom_range(0, word.size() - 1));
                else if (kind == 14)
                    word.insert($urandom_range(0, word.size()),
                                word[$urandom_range(0, word.size() - 1)]);
                push_chars(word, 1'b1);
            end
            // Sometimes leave a word half sent so that the next write cuts it off.
            if ($urandom_range(0, 2) == 0)
            begin
                word = {};
                repeat ($urandom_range(1, 5))
                    word.push_back(char_t'($urandom_range(1, 255)));
                push_chars(word, 1'b0);
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/awf_pkg.sv
rtl/core/awf_slot_cell.sv
rtl/core/awf_slot_chain.sv
rtl/core/anagram_word_filter.sv
rtl/core/awf_checker.sv
tb/sv/anagram_word_filter_tb.sv
